@@ sv/hrx_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package hrx_pkg;

    localparam int unsigned HRX_ADDR_W = 3;
    localparam int unsigned HRX_DATA_W = 32;
    localparam int unsigned HRX_NUM_FIELDS = 8;

    localparam logic [15:0] ENQ_TIMEOUT_RST  = 16'd20000;
    localparam logic [15:0] BYTE_TIMEOUT_RST = 16'd5000;

    localparam logic [7:0]  ENQ_BYTE   = 8'h05;
    localparam logic [7:0]  SIG_BYTE   = 8'h6F;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [6:0]  CRC_LEN    = 7'd126;
    localparam logic [6:0]  LAST_INDEX = 7'd127;

    // register index as decoded from paddr[2]
    typedef enum logic {
        REG_ENQ_TIMEOUT  = 1'b0,
        REG_BYTE_TIMEOUT = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_TIMEOUT      = 3'd1,
        ST_CARRIER_LOST = 3'd2,
        ST_BAD_SIGNAL   = 3'd3,
        ST_BAD_CRC      = 3'd4
    } status_t;

    // fields: zone, net, node, point, capabilities, product, version, serial
    typedef struct packed {
        status_t          status;
        logic [7:0][15:0] fields;
    } hrx_res_t;

    typedef struct packed {
        logic [15:0] enq_timeout;
        logic [15:0] byte_timeout;
    } hrx_cfg_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

@@ sv/hrx_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hrx_cfg (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [hrx_pkg::HRX_ADDR_W-1:0] paddr,
    input  wire logic [hrx_pkg::HRX_DATA_W-1:0] pwdata,
    output logic      [hrx_pkg::HRX_DATA_W-1:0] prdata,
    output logic                               pready,
    output hrx_pkg::hrx_cfg_t                  cfg
);
    import hrx_pkg::*;

    logic [15:0] enq_timeout_reg;
    logic [15:0] byte_timeout_reg;
    logic        wr_en;
    reg_idx_t    idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enq_timeout_reg  <= ENQ_TIMEOUT_RST;
            byte_timeout_reg <= BYTE_TIMEOUT_RST;
        end else if (wr_en) begin
            case (idx)
                REG_ENQ_TIMEOUT:  enq_timeout_reg  <= pwdata[15:0];
                REG_BYTE_TIMEOUT: byte_timeout_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_ENQ_TIMEOUT:  prdata = {{(HRX_DATA_W-16){1'b0}}, enq_timeout_reg};
            REG_BYTE_TIMEOUT: prdata = {{(HRX_DATA_W-16){1'b0}}, byte_timeout_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.enq_timeout  = enq_timeout_reg;
    assign cfg.byte_timeout = byte_timeout_reg;

endmodule

`default_nettype wire

@@ sv/hrx_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hrx_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire logic              req_type,
    input  wire logic [7:0]        data_byte,
    input  wire logic              carrier_detect,
    input  hrx_pkg::hrx_cfg_t      cfg,
    output logic                   res_valid,
    output hrx_pkg::hrx_res_t      res
);
    import hrx_pkg::*;

    logic             in_body_reg,    in_body_next;
    logic [6:0]       byte_index_reg, byte_index_next;
    logic [15:0]      crc_reg,        crc_next;
    logic [15:0]      idle_reg,       idle_next;
    logic             sig_ok_reg,     sig_ok_next;
    logic [7:0][15:0] cap_reg,        cap_next;
    logic [7:0]       crc_lo_reg,     crc_lo_next;

    logic [15:0] idle_inc;
    logic [15:0] limit;
    logic        slot_hit;
    logic [2:0]  slot;

    // pair number to capture slot
    always_comb begin
        slot_hit = 1'b1;
        case (byte_index_reg[6:1])
            6'd14:   slot = 3'd0;
            6'd15:   slot = 3'd1;
            6'd16:   slot = 3'd2;
            6'd17:   slot = 3'd3;
            6'd26:   slot = 3'd4;
            6'd2:    slot = 3'd5;
            6'd1:    slot = 3'd6;
            6'd3:    slot = 3'd7;
            default: begin
                slot     = 3'd0;
                slot_hit = 1'b0;
            end
        endcase
    end

    always_comb begin
        limit = in_body_reg ? cfg.byte_timeout : cfg.enq_timeout;
        if (limit == 16'd0) begin
            limit = 16'd1;
        end
        idle_inc = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;
    end

    always_comb begin
        in_body_next    = in_body_reg;
        byte_index_next = byte_index_reg;
        crc_next        = crc_reg;
        idle_next       = idle_reg;
        sig_ok_next     = sig_ok_reg;
        cap_next        = cap_reg;
        crc_lo_next     = crc_lo_reg;
        res_valid       = 1'b0;
        res.status      = ST_OK;
        res.fields      = '0;

        if (req_type) begin
            idle_next = idle_inc;
            if (idle_inc >= limit) begin
                in_body_next    = 1'b0;
                byte_index_next = '0;
                crc_next        = '0;
                idle_next       = '0;
                sig_ok_next     = 1'b1;
                res_valid       = 1'b1;
                res.status      = ST_TIMEOUT;
            end
        end else begin
            idle_next = '0;
            if (!in_body_reg) begin
                if (data_byte == ENQ_BYTE) begin
                    in_body_next    = 1'b1;
                    byte_index_next = '0;
                    crc_next        = '0;
                    sig_ok_next     = 1'b1;
                end else if (!carrier_detect) begin
                    res_valid  = 1'b1;
                    res.status = ST_CARRIER_LOST;
                end
            end else begin
                if (byte_index_reg < CRC_LEN) begin
                    crc_next = crc16_byte(crc_reg, data_byte);
                end
                if (byte_index_reg[6:1] == 6'd0 && data_byte != SIG_BYTE) begin
                    sig_ok_next = 1'b0;
                end
                if (slot_hit) begin
                    if (!byte_index_reg[0]) begin
                        cap_next[slot] = {8'h00, data_byte};
                    end else begin
                        cap_next[slot] = {data_byte, cap_reg[slot][7:0]};
                    end
                end
                if (byte_index_reg == CRC_LEN) begin
                    crc_lo_next = data_byte;
                end
                if (byte_index_reg == LAST_INDEX) begin
                    res_valid  = 1'b1;
                    res.fields = cap_reg;
                    if (!sig_ok_reg) begin
                        res.status = ST_BAD_SIGNAL;
                    end else if ({data_byte, crc_lo_reg} != crc_reg) begin
                        res.status = ST_BAD_CRC;
                    end else begin
                        res.status = ST_OK;
                    end
                    in_body_next    = 1'b0;
                    byte_index_next = '0;
                    crc_next        = '0;
                    sig_ok_next     = 1'b1;
                end else begin
                    byte_index_next = byte_index_reg + 7'd1;
                end
            end
        end

        if (!step) begin
            res_valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_body_reg    <= 1'b0;
            byte_index_reg <= '0;
            crc_reg        <= '0;
            idle_reg       <= '0;
            sig_ok_reg     <= 1'b1;
        end else if (step) begin
            in_body_reg    <= in_body_next;
            byte_index_reg <= byte_index_next;
            crc_reg        <= crc_next;
            idle_reg       <= idle_next;
            sig_ok_reg     <= sig_ok_next;
        end
    end

    // captured packet fields, no reset needed
    always_ff @(posedge aclk) begin
        if (step) begin
            cap_reg    <= cap_next;
            crc_lo_reg <= crc_lo_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/hello_packet_receiver_crc_check.sv @@
`timescale 1ns / 1ps
`default_nettype none
// throughput: one word per cycle while m_ready does not stall the result
// register, set by the combinational byte crc update between the input
// register and the result register
// reset: synchronous, active low; clears the hunt state, the word valid flags
// and restores the timeout registers to 20000 and 5000

module hello_packet_receiver_crc_check (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_req_type,
    input  wire logic [7:0]                     s_data_byte,
    input  wire logic                           s_carrier_detect,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic      [2:0]                     m_status,
    output logic      [15:0]                    m_remote_zone,
    output logic      [15:0]                    m_remote_net,
    output logic      [15:0]                    m_remote_node,
    output logic      [15:0]                    m_remote_point,
    output logic      [15:0]                    m_capabilities,
    output logic      [15:0]                    m_product_code,
    output logic      [15:0]                    m_hello_version,
    output logic      [15:0]                    m_serial_number,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [hrx_pkg::HRX_ADDR_W-1:0] paddr,
    input  wire logic [hrx_pkg::HRX_DATA_W-1:0] pwdata,
    output logic      [hrx_pkg::HRX_DATA_W-1:0] prdata,
    output logic                                pready
);
    import hrx_pkg::*;

    logic       in_valid_reg;
    logic       in_req_reg;
    logic [7:0] in_byte_reg;
    logic       in_cd_reg;
    logic       out_valid_reg;
    hrx_res_t   out_reg;

    logic       step;
    logic       res_valid;
    hrx_res_t   res;
    hrx_cfg_t   cfg;

    // the input word moves on whenever the result register is free or draining
    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_req_reg  <= s_req_type;
            in_byte_reg <= s_data_byte;
            in_cd_reg   <= s_carrier_detect;
        end
    end

    hrx_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hrx_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (step),
        .req_type       (in_req_reg),
        .data_byte      (in_byte_reg),
        .carrier_detect (in_cd_reg),
        .cfg            (cfg),
        .res_valid      (res_valid),
        .res            (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = out_reg.status;
    assign m_remote_zone   = out_reg.fields[0];
    assign m_remote_net    = out_reg.fields[1];
    assign m_remote_node   = out_reg.fields[2];
    assign m_remote_point  = out_reg.fields[3];
    assign m_capabilities  = out_reg.fields[4];
    assign m_product_code  = out_reg.fields[5];
    assign m_hello_version = out_reg.fields[6];
    assign m_serial_number = out_reg.fields[7];

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status <= ST_BAD_CRC))
        else $error("result status out of range");

    a_no_fields_on_abort: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_TIMEOUT || m_status == ST_CARRIER_LOST)) |->
        (m_remote_zone == 16'd0 && m_remote_net == 16'd0 && m_serial_number == 16'd0
         && m_capabilities == 16'd0))
        else $error("aborted result carries packet fields");

    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !step) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("input word lost while stalled");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !step)
        else $error("result register overwritten while held");

endmodule

`default_nettype wire
